[rtl/srsw_pkg.sv]
// Types and codes shared by the selective-repeat sender window.
`timescale 1ns / 1ps

package srsw_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_SEND  = 2'd1,
        MODE_ACK   = 2'd2,
        MODE_POLL  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] ack_byte;
    } in_item_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  seq_tag;
        logic [15:0] packet_index;
        logic        timeout_fired;
        logic [15:0] resend_from;
        logic        done_res;
    } out_item_t;

    // Register index, taken from paddr[2]
    localparam logic REG_TOTAL_PACKETS = 1'b0;
    localparam logic REG_WAIT_LIMIT    = 1'b1;

    localparam logic [15:0] TOTAL_PACKETS_RESET = 16'd0;
    localparam logic [7:0]  WAIT_LIMIT_RESET    = 8'd20;
    localparam logic [15:0] COUNT_MAX           = 16'hFFFF;

endpackage

[rtl/selective_repeat_sender_window.sv]
// Selective-repeat ARQ sender window: sequencer, window state and config registers.
`timescale 1ns / 1ps

// Sender side of a selective-repeat ARQ window over SEQ_COUNT sequence numbers.
// Input channel s_*: one event per item (start, send slot, ack, idle poll).
// Result channel m_*: exactly one result item per event, held in an output
// register until m_ready takes it.
// Steps: an event passes accept, distance, apply and finish before m_valid
// rises, while the output register is free. An ack equal to the window base
// adds a slide step, repeated for each further acked entry the window slides
// past. The modular window distance comes from one shared subtract unit, and
// the slide walks the ack marks one entry per cycle through a single read port.
// Throughput: one item at a time; s_ready is high only while the sequencer
// is idle, so a new item is taken only after the last one has left finish.
// A stalled receiver holds m_valid and the result; the next item is still taken
// and its result waits in the finish step until the output register frees up.
// Reset clears the window, counters and ack marks and loads
// total_packets 0 and wait_limit 20. Configuration goes through the APB port
// (total_packets at 0x0, wait_limit at 0x4) and should be written while idle.
module selective_repeat_sender_window #(
    parameter int SEQ_COUNT = 20,
    parameter int WINDOW    = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  srsw_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output srsw_pkg::out_item_t   m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SEQ_W = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
    localparam logic [8:0] SEQ_MOD  = 9'(SEQ_COUNT);
    localparam logic [7:0] SEQ_LAST = 8'(SEQ_COUNT - 1);
    localparam logic [7:0] WIN_SIZE = 8'(WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_APPLY,
        ST_SLIDE,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    srsw_pkg::in_item_t  in_reg, in_next;
    srsw_pkg::out_item_t res_reg, res_next;
    srsw_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [15:0]         total_packets_reg;
    logic [7:0]          wait_limit_reg;

    logic [SEQ_W-1:0]    next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]    window_base_reg, window_base_next;
    logic [15:0]         sent_count_reg, sent_count_next;
    logic [15:0]         acked_count_reg, acked_count_next;
    logic [SEQ_COUNT-1:0] ack_marks_reg, ack_marks_next;
    logic [7:0]          idle_polls_reg, idle_polls_next;
    logic [SEQ_W-1:0]    dist_reg, dist_next;

    // Shared modular-distance unit
    logic [SEQ_W-1:0]    dist_to;
    logic [8:0]          dist_raw;
    logic [8:0]          dist_wrap;
    logic [SEQ_W-1:0]    dist_res;

    // Single read port on the ack marks
    logic [SEQ_W-1:0]    mark_addr;
    logic                mark_rd;

    logic [7:0]          ack_idx;
    logic                ack_idx_ok;
    logic [SEQ_W-1:0]    ack_seq;
    logic                in_window;
    logic [8:0]          poll_count;
    logic [15:0]         sent_back;
    logic [SEQ_W-1:0]    base_inc;

    logic                cfg_wr;

    function automatic logic [SEQ_W-1:0] wrap_inc(input logic [SEQ_W-1:0] s);
        logic [SEQ_W-1:0] r;
        if (8'(s) == SEQ_LAST) begin
            r = '0;
        end else begin
            r = s + SEQ_W'(1);
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        logic [15:0] r;
        if (c == srsw_pkg::COUNT_MAX) begin
            r = c;
        end else begin
            r = c + 16'd1;
        end
        return r;
    endfunction

    assign ack_idx    = in_reg.ack_byte - 8'd1;
    assign ack_idx_ok = ack_idx <= SEQ_LAST;
    assign ack_seq    = ack_idx[SEQ_W-1:0];

    assign dist_to   = (state_reg == ST_CALC && in_reg.mode == srsw_pkg::MODE_ACK) ?
                       ack_seq : next_seq_reg;
    assign dist_raw  = 9'(dist_to) - 9'(window_base_reg);
    assign dist_wrap = dist_raw[8] ? dist_raw + SEQ_MOD : dist_raw;
    assign dist_res  = dist_wrap[SEQ_W-1:0];

    assign in_window = 8'(dist_reg) < WIN_SIZE;
    assign base_inc  = wrap_inc(window_base_reg);
    assign poll_count = 9'(idle_polls_reg) + 9'd1;
    assign sent_back  = (sent_count_reg > 16'(dist_reg)) ?
                        sent_count_reg - 16'(dist_reg) : 16'd0;

    always_comb begin
        priority if (state_reg == ST_SLIDE) begin
            mark_addr = window_base_reg;
        end else if (in_reg.mode == srsw_pkg::MODE_ACK) begin
            mark_addr = ack_seq;
        end else begin
            mark_addr = next_seq_reg;
        end
    end
    assign mark_rd = ack_marks_reg[mark_addr];

    always_comb begin
        state_next       = state_reg;
        in_next          = in_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        next_seq_next    = next_seq_reg;
        window_base_next = window_base_reg;
        sent_count_next  = sent_count_reg;
        acked_count_next = acked_count_reg;
        ack_marks_next   = ack_marks_reg;
        idle_polls_next  = idle_polls_reg;
        dist_next        = dist_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    in_next    = s_data;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                dist_next  = dist_res;
                res_next   = '0;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                state_next = ST_FINISH;
                unique case (in_reg.mode)
                    srsw_pkg::MODE_START: begin
                        next_seq_next    = '0;
                        window_base_next = '0;
                        sent_count_next  = '0;
                        acked_count_next = '0;
                        ack_marks_next   = '0;
                        idle_polls_next  = '0;
                    end
                    srsw_pkg::MODE_SEND: begin
                        if (in_window && sent_count_reg < total_packets_reg) begin
                            if (!mark_rd) begin
                                res_next.send_valid   = 1'b1;
                                res_next.seq_tag      = 8'(next_seq_reg) + 8'd1;
                                res_next.packet_index = sent_count_reg;
                            end
                            ack_marks_next[next_seq_reg] = 1'b0;
                            next_seq_next   = wrap_inc(next_seq_reg);
                            sent_count_next = sat_inc(sent_count_reg);
                        end
                    end
                    srsw_pkg::MODE_ACK: begin
                        idle_polls_next = '0;
                        if (ack_idx_ok) begin
                            if (ack_seq == window_base_reg) begin
                                // pass the base entry, then walk further acked ones
                                acked_count_next = sat_inc(acked_count_reg);
                                ack_marks_next[window_base_reg] = 1'b0;
                                window_base_next = base_inc;
                                if (next_seq_reg == window_base_reg) begin
                                    next_seq_next   = base_inc;
                                    sent_count_next = sat_inc(sent_count_reg);
                                end
                                state_next = ST_SLIDE;
                            end else if (in_window && !mark_rd) begin
                                ack_marks_next[ack_seq] = 1'b1;
                                acked_count_next = sat_inc(acked_count_reg);
                            end
                        end
                    end
                    srsw_pkg::MODE_POLL: begin
                        if (poll_count > 9'(wait_limit_reg)) begin
                            // roll back to the base, keep the marks
                            sent_count_next        = sent_back;
                            next_seq_next          = window_base_reg;
                            idle_polls_next        = '0;
                            res_next.timeout_fired = 1'b1;
                            res_next.resend_from   = sent_back;
                        end else begin
                            idle_polls_next = poll_count[7:0];
                        end
                    end
                    default: ;
                endcase
            end
            ST_SLIDE: begin
                if (mark_rd) begin
                    ack_marks_next[window_base_reg] = 1'b0;
                    window_base_next = base_inc;
                    if (next_seq_reg == window_base_reg) begin
                        next_seq_next   = base_inc;
                        sent_count_next = sat_inc(sent_count_reg);
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_next          = res_reg;
                    out_next.done_res = (in_reg.mode == srsw_pkg::MODE_ACK) &&
                                        (acked_count_reg == total_packets_reg);
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            next_seq_reg    <= '0;
            window_base_reg <= '0;
            sent_count_reg  <= '0;
            acked_count_reg <= '0;
            ack_marks_reg   <= '0;
            idle_polls_reg  <= '0;
        end else begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            next_seq_reg    <= next_seq_next;
            window_base_reg <= window_base_next;
            sent_count_reg  <= sent_count_next;
            acked_count_reg <= acked_count_next;
            ack_marks_reg   <= ack_marks_next;
            idle_polls_reg  <= idle_polls_next;
        end
        in_reg   <= in_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        dist_reg <= dist_next;
    end

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_packets_reg <= srsw_pkg::TOTAL_PACKETS_RESET;
            wait_limit_reg    <= srsw_pkg::WAIT_LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                srsw_pkg::REG_TOTAL_PACKETS: total_packets_reg <= pwdata[15:0];
                srsw_pkg::REG_WAIT_LIMIT:    wait_limit_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            srsw_pkg::REG_TOTAL_PACKETS: prdata = 32'(total_packets_reg);
            srsw_pkg::REG_WAIT_LIMIT:    prdata = 32'(wait_limit_reg);
            default:                     prdata = '0;
        endcase
    end

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // An accepted item always starts with the distance step
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_CALC)
        else $error("accepted item did not start the sequencer");

    // Outstanding entries never exceed the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> 8'(dist_res) <= WIN_SIZE)
        else $error("window overrun");

    // After any event the base entry is never left marked
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !ack_marks_reg[window_base_reg])
        else $error("acked entry left at window base");

    // A send and a timeout never come from the same event
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.send_valid && m_data.timeout_fired))
        else $error("send and timeout in one result");

    // The slide walk always ends through the finish step
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SLIDE |=> state_reg == ST_SLIDE || state_reg == ST_FINISH)
        else $error("slide walk left by wrong path");

endmodule

[sim/srsw_window_checker.sv]
// Result checker for the selective-repeat sender window: predicts each result and compares.
`timescale 1ns / 1ps

module srsw_window_checker #(
    parameter int SEQ_COUNT = 20,
    parameter int WINDOW    = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  srsw_pkg::in_item_t   s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  srsw_pkg::out_item_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   pending,
    output int                   results_checked,
    output int                   sends_seen,
    output int                   rollbacks_seen,
    output int                   finishes_seen
);

    localparam int PRINT_CAP = 20;

    // Register copies and window state, held at the block's widths but for the byte-wide positions
    logic [15:0]          total_cfg;
    logic [7:0]           limit_cfg;
    logic [7:0]           next_pos;
    logic [7:0]           base_pos;
    logic [15:0]          sent_total;
    logic [15:0]          acked_total;
    logic [SEQ_COUNT-1:0] ack_mark;
    logic [7:0]           idle_run;

    srsw_pkg::out_item_t expected_results[$];
    int        miss_total;
    int        checked_total;
    int        send_total;
    int        rollback_total;
    int        finish_total;

    function automatic int seq_gap(input logic [7:0] from, input logic [7:0] to);
        return (int'(to) + SEQ_COUNT - int'(from)) % SEQ_COUNT;
    endfunction

    function automatic logic [7:0] wrap_next(input logic [7:0] pos);
        return 8'((int'(pos) + 1) % SEQ_COUNT);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] count);
        return (count == srsw_pkg::COUNT_MAX) ? count : count + 16'd1;
    endfunction

    task automatic clear_window();
        next_pos    = '0;
        base_pos    = '0;
        sent_total  = '0;
        acked_total = '0;
        ack_mark    = '0;
        idle_run    = '0;
    endtask

    // Advance the base past one entry; drag the send position along if it sits there
    task automatic slide_past(input logic [7:0] pos);
        ack_mark[pos] = 1'b0;
        base_pos = wrap_next(pos);
        if (next_pos == pos) begin
            next_pos   = wrap_next(pos);
            sent_total = sat_inc(sent_total);
        end
    endtask

    task automatic step_window(input srsw_pkg::in_item_t ev,
                               output srsw_pkg::out_item_t res);
        int idx;
        int k;
        int back;
        int n;
        res = '0;
        case (ev.mode)
            srsw_pkg::MODE_START: begin
                clear_window();
            end
            srsw_pkg::MODE_SEND: begin
                if (seq_gap(base_pos, next_pos) < WINDOW && sent_total < total_cfg) begin
                    // an entry already acked is skipped but still counts as sent
                    if (!ack_mark[next_pos]) begin
                        res.send_valid   = 1'b1;
                        res.seq_tag      = next_pos + 8'd1;
                        res.packet_index = sent_total;
                    end
                    ack_mark[next_pos] = 1'b0;
                    next_pos   = wrap_next(next_pos);
                    sent_total = sat_inc(sent_total);
                end
            end
            srsw_pkg::MODE_ACK: begin
                idx = (int'(ev.ack_byte) + 255) & 255;
                if (idx < SEQ_COUNT) begin
                    if (idx == int'(base_pos)) begin
                        acked_total = sat_inc(acked_total);
                        slide_past(8'(idx));
                        for (k = 1; k < SEQ_COUNT && ack_mark[(idx + k) % SEQ_COUNT]; k++)
                            slide_past(8'((idx + k) % SEQ_COUNT));
                    end else if (seq_gap(base_pos, 8'(idx)) < WINDOW) begin
                        if (!ack_mark[idx]) begin
                            ack_mark[idx] = 1'b1;
                            acked_total   = sat_inc(acked_total);
                        end
                    end
                end
                idle_run     = '0;
                res.done_res = (acked_total == total_cfg);
            end
            default: begin
                n = int'(idle_run) + 1;
                if (n > int'(limit_cfg)) begin
                    // roll back to the base, never below zero
                    back = seq_gap(base_pos, next_pos);
                    sent_total = (int'(sent_total) > back) ? sent_total - 16'(back) : 16'd0;
                    next_pos = base_pos;
                    idle_run = '0;
                    res.timeout_fired = 1'b1;
                    res.resend_from   = sent_total;
                end else begin
                    idle_run = 8'(n);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        if (miss_total < PRINT_CAP)
            $display("checker: result %0d at %0t ns: %s", checked_total, $time, what);
        miss_total++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    always @(posedge aclk) begin : watch
        srsw_pkg::out_item_t want;
        if (!aresetn) begin
            clear_window();
            total_cfg = srsw_pkg::TOTAL_PACKETS_RESET;
            limit_cfg = srsw_pkg::WAIT_LIMIT_RESET;
            expected_results.delete();
            miss_total     = 0;
            checked_total  = 0;
            send_total     = 0;
            rollback_total = 0;
            finish_total   = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == srsw_pkg::REG_TOTAL_PACKETS)
                    total_cfg = pwdata[15:0];
                else
                    limit_cfg = pwdata[7:0];
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result arrived with none outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("send_valid", 16'(m_data.send_valid),
                                16'(want.send_valid));
                    check_field("seq_tag", 16'(m_data.seq_tag), 16'(want.seq_tag));
                    check_field("packet_index", m_data.packet_index, want.packet_index);
                    check_field("timeout_fired", 16'(m_data.timeout_fired),
                                16'(want.timeout_fired));
                    check_field("resend_from", m_data.resend_from, want.resend_from);
                    check_field("done_res", 16'(m_data.done_res), 16'(want.done_res));
                    send_total     += int'(want.send_valid);
                    rollback_total += int'(want.timeout_fired);
                    finish_total   += int'(want.done_res);
                end
                checked_total++;
            end
            if (s_valid && s_ready) begin
                step_window(s_data, want);
                expected_results.push_back(want);
            end
        end
        fail_count      <= miss_total;
        pending         <= expected_results.size();
        results_checked <= checked_total;
        sends_seen      <= send_total;
        rollbacks_seen  <= rollback_total;
        finishes_seen   <= finish_total;
    end

endmodule

[sim/selective_repeat_sender_window_tb.sv]
// Testbench top for the selective-repeat sender window: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module selective_repeat_sender_window_tb;

    localparam int SEQ_COUNT      = 20;
    localparam int WINDOW         = 10;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAG_HISTORY    = 10;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    srsw_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b1;
    srsw_pkg::out_item_t m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    int fail_count;
    int pending;
    int results_checked;
    int sends_seen;
    int rollbacks_seen;
    int finishes_seen;

    bit         idling_on   = 1'b1;
    int         stall_left  = 0;
    int         quiet_count = 0;
    int         items_issued = 0;
    logic [7:0] recent_tags[$];

    selective_repeat_sender_window #(
        .SEQ_COUNT (SEQ_COUNT),
        .WINDOW    (WINDOW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    srsw_window_checker #(
        .SEQ_COUNT (SEQ_COUNT),
        .WINDOW    (WINDOW)
    ) window_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .sends_seen      (sends_seen),
        .rollbacks_seen  (rollbacks_seen),
        .finishes_seen   (finishes_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver stalls in bursts of random length, only while idling_on is set
    always @(posedge aclk) begin
        if (!idling_on) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 12);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Keep the latest sent tags so that most acks name packets really in flight
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_data.send_valid) begin
            recent_tags.push_back(m_data.seq_tag);
            if (recent_tags.size() > TAG_HISTORY)
                recent_tags.delete(0);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count == WATCHDOG_LIMIT) begin
            $display("tb: timeout after %0d cycles without progress", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic srsw_pkg::in_item_t make_event(input srsw_pkg::mode_t mode,
                                                      input logic [7:0] ack_byte);
        srsw_pkg::in_item_t ev;
        ev.mode     = mode;
        ev.ack_byte = ack_byte;
        return ev;
    endfunction

    function automatic srsw_pkg::in_item_t random_event();
        srsw_pkg::in_item_t ev;
        int       roll;
        int       pick;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        ev.ack_byte = 8'($urandom_range(0, 255));
        if (roll < 5) begin
            ev.mode = srsw_pkg::mode_t'($urandom_range(0, 3));
        end else if (roll < 8) begin
            ev.mode = srsw_pkg::MODE_START;
        end else if (roll < 46) begin
            ev.mode = srsw_pkg::MODE_SEND;
        end else if (roll < 80) begin
            ev.mode = srsw_pkg::MODE_ACK;
            if (pick < 65 && recent_tags.size() > 0)
                ev.ack_byte = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
            else if (pick < 90)
                ev.ack_byte = 8'($urandom_range(1, SEQ_COUNT));
        end else begin
            ev.mode = srsw_pkg::MODE_POLL;
        end
        return ev;
    endfunction

    // Present one item and hold it until taken; valid stays high for the next item
    task automatic issue_event(input srsw_pkg::in_item_t ev);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_issued++;
    endtask

    // Drain all outstanding results, then let the sequencer finish any slide
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] total, input logic [7:0] limit,
                             input int count, input bit with_gaps);
        int k;
        idling_on <= with_gaps;
        settle();
        write_reg(srsw_pkg::REG_TOTAL_PACKETS, {16'd0, total});
        write_reg(srsw_pkg::REG_WAIT_LIMIT, {24'd0, limit});
        issue_event(make_event(srsw_pkg::MODE_START, 8'($urandom_range(0, 255))));
        for (k = 0; k < count; k++) begin
            // clear the idle count, then poll until the longest timeout fires
            if (limit == 8'hFF && k == count / 2) begin
                issue_event(make_event(srsw_pkg::MODE_ACK, 8'd0));
                repeat (256)
                    issue_event(make_event(srsw_pkg::MODE_POLL, 8'($urandom_range(0, 255))));
            end
            issue_event(random_event());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: nothing to send, base ack drags the send position
        issue_event(make_event(srsw_pkg::MODE_SEND, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'h01));
        issue_event(make_event(srsw_pkg::MODE_POLL, 8'hFF));

        settle();
        write_reg(srsw_pkg::REG_TOTAL_PACKETS, 32'd4);
        write_reg(srsw_pkg::REG_WAIT_LIMIT, 32'd1);
        issue_event(make_event(srsw_pkg::MODE_START, 8'hFF));
        issue_event(make_event(srsw_pkg::MODE_SEND, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd3));
        issue_event(make_event(srsw_pkg::MODE_SEND, 8'hAA));
        issue_event(make_event(srsw_pkg::MODE_SEND, 8'h55));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd3));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd0));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd255));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd21));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd16));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd1));
        issue_event(make_event(srsw_pkg::MODE_POLL, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_POLL, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_SEND, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_SEND, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_SEND, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_SEND, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd2));
        issue_event(make_event(srsw_pkg::MODE_START, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd2));
        issue_event(make_event(srsw_pkg::MODE_SEND, 8'h00));
        issue_event(make_event(srsw_pkg::MODE_ACK, 8'd1));

        run_phase(16'd12, 8'd3, 300, 1'b1);
        run_phase(16'd0, 8'd0, 120, 1'b1);
        run_phase(16'hFFFF, 8'hFF, 260, 1'b1);
        run_phase(16'd30, 8'd1, 250, 1'b0);
        run_phase(16'd1, 8'd20, 120, 1'b1);
        run_phase(16'd200, 8'd7, 300, 1'b1);
        run_phase(16'd8, 8'd2, 250, 1'b0);

        settle();
        $display("summary: %0d events over nine register settings, %0d results checked",
                 items_issued, results_checked);
        $display("summary: %0d packets sent, %0d timeout rollbacks, %0d completion flags",
                 sends_seen, rollbacks_seen, finishes_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
